// ===== hdl/rvso_pkg.sv =====
// ---------------------------------------------------------------------------
// rvso_pkg : shared types and tables for the relay and valve shift-out block
// Command codes, image field positions, the relay bit map, the half-step
// phase table and the burst request passed to the serializer.
// ---------------------------------------------------------------------------
package rvso_pkg;

    localparam int IMAGE_W = 16;
    localparam int PHASE_W = 3;
    localparam int NIBBLE_W = 4;
    localparam int COUNT_W = 4;

    // Command codes
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    // Image fields: valve A in bits 12..9 of the shared image,
    // valve B in bits 15..12 of its own image
    localparam logic [IMAGE_W-1:0] VALVE_A_FIELD = 16'h1e00;
    localparam logic [IMAGE_W-1:0] VALVE_B_FIELD = 16'hf000;
    localparam int VALVE_A_LSB = 9;
    localparam int VALVE_B_LSB = 12;

    localparam logic [COUNT_W-1:0] LAST_BIT = 4'd15;

    // Request from the command stage to the serializer
    typedef struct packed {
        logic                valid;
        logic [IMAGE_W-1:0]  image;
        logic [NIBBLE_W-1:0] sub_bits;
    } burst_t;

    // Relay number to image bit position
    function automatic logic [COUNT_W-1:0] relay_bit_pos(input logic [3:0] num);
        logic [COUNT_W-1:0] pos;
        case (num)
            4'd0:    pos = 4'd0;
            4'd1:    pos = 4'd7;
            4'd2:    pos = 4'd6;
            4'd3:    pos = 4'd5;
            4'd4:    pos = 4'd4;
            4'd5:    pos = 4'd3;
            4'd6:    pos = 4'd2;
            4'd7:    pos = 4'd1;
            4'd8:    pos = 4'd15;
            4'd9:    pos = 4'd14;
            4'd10:   pos = 4'd10;
            default: pos = 4'd13;
        endcase
        return pos;
    endfunction

    // Half-step coil pattern per phase, as a 4-bit field value. Both valves
    // use the same sequence (0x1000, 0x1800, ... for A; 0x8000, 0xc000, ...
    // for B), only the field position differs.
    function automatic logic [NIBBLE_W-1:0] half_step(input logic [PHASE_W-1:0] ph);
        logic [NIBBLE_W-1:0] pat;
        case (ph)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hc;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

// ===== hdl/rvso_if.sv =====
// ---------------------------------------------------------------------------
// rvso_if : channel interfaces for the relay and valve shift-out block
// Command channel and serial bit channel, each with valid/ready handshake.
// ---------------------------------------------------------------------------
interface rvso_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] relay_number;
    logic       valve_select;
    logic       step_back;

    modport source (output valid, action, relay_number, valve_select, step_back,
                    input ready);
    modport sink   (input valid, action, relay_number, valve_select, step_back,
                    output ready);
endinterface

interface rvso_bit_if;
    logic       valid;
    logic       ready;
    logic       serial_bit;
    logic       latch_strobe;
    logic [3:0] sub_valve_bits;

    modport source (output valid, serial_bit, latch_strobe, sub_valve_bits,
                    input ready);
    modport sink   (input valid, serial_bit, latch_strobe, sub_valve_bits,
                    output ready);
endinterface

// ===== hdl/rvso_cmd.sv =====
// ---------------------------------------------------------------------------
// rvso_cmd : command register and image update
// Holds one command request, computes the next relay/valve image and valve
// phases, and commits when the image is unchanged or the serializer can
// take a new burst.
// ---------------------------------------------------------------------------
module rvso_cmd #(
    parameter int RELAY_COUNT = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    rvso_cmd_if.sink        cmd,
    input  logic            load_ready,
    output rvso_pkg::burst_t burst
);
    import rvso_pkg::*;

    // Command register
    logic                cmd_valid_reg;
    logic [1:0]          action_reg;
    logic [3:0]          relay_reg;
    logic                vsel_reg;
    logic                back_reg;

    // Block state
    logic [IMAGE_W-1:0]  image_reg, image_next;
    logic [IMAGE_W-1:0]  last_sent_reg;
    logic [IMAGE_W-1:0]  sub_image_reg, sub_image_next;
    logic [PHASE_W-1:0]  phase_a_reg, phase_a_next;
    logic [PHASE_W-1:0]  phase_b_reg, phase_b_next;

    logic                in_range;
    logic [IMAGE_W-1:0]  relay_mask;
    logic [PHASE_W-1:0]  phase_cur;
    logic [PHASE_W-1:0]  phase_moved;
    logic [NIBBLE_W-1:0] pat;
    logic                changed;
    logic                commit;

    // Decode relay and valve pattern
    assign in_range   = {1'b0, relay_reg} < 5'(RELAY_COUNT);
    assign relay_mask = IMAGE_W'(1) << relay_bit_pos(relay_reg);
    assign phase_cur  = vsel_reg ? phase_b_reg : phase_a_reg;
    assign pat        = half_step(phase_cur);
    assign phase_moved = back_reg ? phase_cur - PHASE_W'(1) : phase_cur + PHASE_W'(1);

    // Next image and phases
    always_comb
    begin
        image_next     = image_reg;
        sub_image_next = sub_image_reg;
        phase_a_next   = phase_a_reg;
        phase_b_next   = phase_b_reg;
        case (action_reg)
            ACT_SET:
            begin
                if (in_range)
                    image_next = image_reg | relay_mask;
            end
            ACT_CLEAR:
            begin
                if (in_range)
                    image_next = image_reg & ~relay_mask;
            end
            ACT_STEP:
            begin
                if (vsel_reg)
                begin
                    sub_image_next = (sub_image_reg & ~VALVE_B_FIELD)
                                   | (IMAGE_W'(pat) << VALVE_B_LSB);
                    phase_b_next   = phase_moved;
                end
                else
                begin
                    image_next   = (image_reg & ~VALVE_A_FIELD)
                                 | (IMAGE_W'(pat) << VALVE_A_LSB);
                    phase_a_next = phase_moved;
                end
            end
            default: ;
        endcase
    end

    assign changed = image_next != last_sent_reg;
    assign commit  = cmd_valid_reg && (!changed || load_ready);
    assign cmd.ready = !cmd_valid_reg || commit;

    assign burst.valid    = cmd_valid_reg && changed;
    assign burst.image    = image_next;
    assign burst.sub_bits = sub_image_next[IMAGE_W-1 -: NIBBLE_W];

    // Hold command request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (cmd.ready)
            cmd_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            action_reg <= cmd.action;
            relay_reg  <= cmd.relay_number;
            vsel_reg   <= cmd.valve_select;
            back_reg   <= cmd.step_back;
        end
    end

    // Commit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_reg     <= '0;
            last_sent_reg <= '0;
            sub_image_reg <= '0;
            phase_a_reg   <= '0;
            phase_b_reg   <= '0;
        end
        else if (commit)
        begin
            image_reg     <= image_next;
            sub_image_reg <= sub_image_next;
            phase_a_reg   <= phase_a_next;
            phase_b_reg   <= phase_b_next;
            if (changed)
                last_sent_reg <= image_next;
        end
    end

endmodule

// ===== hdl/rvso_shift.sv =====
// ---------------------------------------------------------------------------
// rvso_shift : image serializer
// Loads a 16-bit image and presents it MSB first, one bit per request,
// strobing the latch on the last bit.
// ---------------------------------------------------------------------------
module rvso_shift (
    input  logic             clk,
    input  logic             rst_n,
    input  rvso_pkg::burst_t burst,
    output logic             load_ready,
    rvso_bit_if.source       bits
);
    import rvso_pkg::*;

    logic                busy_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [IMAGE_W-1:0]  shift_reg;
    logic [NIBBLE_W-1:0] sub_reg;
    logic                fire;
    logic                last;

    assign fire       = busy_reg && bits.ready;
    assign last       = count_reg == LAST_BIT;
    assign load_ready = !busy_reg || (fire && last);

    assign bits.valid          = busy_reg;
    assign bits.serial_bit     = shift_reg[IMAGE_W-1];
    assign bits.latch_strobe   = last;
    assign bits.sub_valve_bits = sub_reg;

    // Track burst progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (load_ready && burst.valid)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_reg + COUNT_W'(1);
            if (last)
                busy_reg <= 1'b0;
        end
    end

    // Load or advance the shift register
    always_ff @(posedge clk)
    begin
        if (load_ready && burst.valid)
        begin
            shift_reg <= burst.image;
            sub_reg   <= burst.sub_bits;
        end
        else if (fire)
            shift_reg <= shift_reg << 1;
    end

endmodule

// ===== hdl/relay_valve_shift_out.sv =====
// ---------------------------------------------------------------------------
// relay_valve_shift_out : relay and stepper valve driver with serial output
// Applies relay set/clear and valve step commands to an output image and
// shifts each changed image out MSB first with a latch strobe.
// ---------------------------------------------------------------------------
//   channel | dir | payload
//   cmd     | in  | action, relay_number, valve_select, step_back
//   bits    | out | serial_bit, latch_strobe, sub_valve_bits
//
// A command that leaves the image unchanged commits from the command
// register, so such commands flow one per cycle. A command that changes
// the image produces 16 bit requests; the serializer holds one burst and
// loads the next as the last bit of the current one is taken, shifting
// out one bit per cycle while bits.ready is high. The next command waits in
// the command register while a burst drains. Reset clears the images,
// phases and all valid flags. A stalled output holds its bit and strobe.
// ---------------------------------------------------------------------------
module relay_valve_shift_out #(
    parameter int RELAY_COUNT = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    rvso_cmd_if.sink   cmd,
    rvso_bit_if.source bits
);
    import rvso_pkg::*;

    burst_t burst;
    logic   load_ready;

    rvso_cmd #(
        .RELAY_COUNT(RELAY_COUNT)
    ) u_cmd (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_ready (load_ready),
        .burst      (burst)
    );

    rvso_shift u_shift (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst      (burst),
        .load_ready (load_ready),
        .bits       (bits)
    );

endmodule

// ===== dv/relay_valve_shift_out_tb.sv =====
// ---------------------------------------------------------------------------
// relay_valve_shift_out_tb : self-checking bench for the relay and valve driver
// Walks a short table of hand-picked commands, then several hundred random
// ones, with random gaps on the command side and random stalls on the bit
// side. A local model of the relay image and the valve phases predicts each
// 16-bit burst; every bit request is checked field by field in order.
// ---------------------------------------------------------------------------
module relay_valve_shift_out_tb;

    import rvso_pkg::*;

    localparam int RELAY_COUNT = 10;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int DIRECTED_ROWS = 25;

    localparam logic [1:0] ACT_NONE = 2'd3;

    // How a table row gets its expected bits
    localparam logic [1:0] ROW_PREDICT = 2'd0;
    localparam logic [1:0] ROW_BURST   = 2'd1;
    localparam logic [1:0] ROW_QUIET   = 2'd2;

    // Relay number to image bit, entry 15 first
    localparam logic [15:0][3:0] RELAY_POS = {
        4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd10, 4'd14, 4'd15,
        4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,  4'd0
    };

    // Half-step coil patterns, phase 7 first
    localparam logic [7:0][15:0] VALVE_A_STEPS = {
        16'h1200, 16'h0200, 16'h0600, 16'h0400,
        16'h0c00, 16'h0800, 16'h1800, 16'h1000
    };
    localparam logic [7:0][15:0] VALVE_B_STEPS = {
        16'h9000, 16'h1000, 16'h3000, 16'h2000,
        16'h6000, 16'h4000, 16'hc000, 16'h8000
    };

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  relay;
        logic        vsel;
        logic        back;
        logic [1:0]  kind;
        logic [15:0] image;
        logic [3:0]  sub;
    } cmd_row_t;

    typedef struct packed {
        logic       sbit;
        logic       strobe;
        logic [3:0] sub;
    } shift_bit_t;

    logic clk;
    logic rst_n;

    rvso_cmd_if cmd_ch ();
    rvso_bit_if bit_ch ();

    relay_valve_shift_out #(
        .RELAY_COUNT(RELAY_COUNT)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .bits (bit_ch)
    );

    // Model state
    logic [15:0] relay_image;
    logic [15:0] sent_image;
    logic [15:0] sub_image;
    logic [2:0]  valve_phase [2];

    shift_bit_t expected_bits [$];
    int error_count;
    int cycle_count;

    // Pacing state for both sides
    logic send_free;
    int   send_left;
    logic recv_free;
    int   recv_left;

    // Hand-picked commands: relay extremes, ignored relays, unused action,
    // phase wrap in both directions and a valve B step with no output change
    cmd_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ACT_SET,   4'd0,  1'b0, 1'b0, ROW_BURST,   16'h0001, 4'h0},
        '{ACT_SET,   4'd9,  1'b1, 1'b1, ROW_BURST,   16'h4001, 4'h0},
        '{ACT_SET,   4'd8,  1'b0, 1'b0, ROW_BURST,   16'hc001, 4'h0},
        '{ACT_SET,   4'd10, 1'b0, 1'b0, ROW_QUIET,   16'h0000, 4'h0},
        '{ACT_SET,   4'd15, 1'b1, 1'b1, ROW_QUIET,   16'h0000, 4'h0},
        '{ACT_CLEAR, 4'd0,  1'b0, 1'b0, ROW_BURST,   16'hc000, 4'h0},
        '{ACT_CLEAR, 4'd0,  1'b0, 1'b0, ROW_QUIET,   16'h0000, 4'h0},
        '{ACT_NONE,  4'd5,  1'b1, 1'b1, ROW_QUIET,   16'h0000, 4'h0},
        '{ACT_STEP,  4'd0,  1'b1, 1'b0, ROW_QUIET,   16'h0000, 4'h0},
        '{ACT_STEP,  4'd0,  1'b0, 1'b0, ROW_BURST,   16'hd000, 4'h8},
        '{ACT_STEP,  4'd0,  1'b0, 1'b1, ROW_BURST,   16'hd800, 4'h8},
        '{ACT_STEP,  4'd0,  1'b0, 1'b1, ROW_BURST,   16'hd000, 4'h8},
        '{ACT_STEP,  4'd15, 1'b0, 1'b0, ROW_BURST,   16'hd200, 4'h8},
        '{ACT_CLEAR, 4'd8,  1'b0, 1'b0, ROW_BURST,   16'h5200, 4'h8},
        '{ACT_CLEAR, 4'd9,  1'b0, 1'b0, ROW_BURST,   16'h1200, 4'h8},
        '{ACT_SET,   4'd1,  1'b0, 1'b0, ROW_PREDICT, 16'h0000, 4'h0},
        '{ACT_SET,   4'd2,  1'b0, 1'b0, ROW_PREDICT, 16'h0000, 4'h0},
        '{ACT_SET,   4'd3,  1'b0, 1'b0, ROW_PREDICT, 16'h0000, 4'h0},
        '{ACT_SET,   4'd4,  1'b0, 1'b0, ROW_PREDICT, 16'h0000, 4'h0},
        '{ACT_SET,   4'd5,  1'b0, 1'b0, ROW_PREDICT, 16'h0000, 4'h0},
        '{ACT_SET,   4'd6,  1'b0, 1'b0, ROW_PREDICT, 16'h0000, 4'h0},
        '{ACT_SET,   4'd7,  1'b0, 1'b0, ROW_PREDICT, 16'h0000, 4'h0},
        '{ACT_STEP,  4'd0,  1'b1, 1'b1, ROW_PREDICT, 16'h0000, 4'h0},
        '{ACT_STEP,  4'd0,  1'b1, 1'b1, ROW_PREDICT, 16'h0000, 4'h0},
        '{ACT_CLEAR, 4'd4,  1'b1, 1'b0, ROW_PREDICT, 16'h0000, 4'h0}
    };

    // Apply one command to the model image and phases; report a changed image
    function automatic void update_image(input cmd_row_t c, output logic changed,
                                         output logic [15:0] img, output logic [3:0] sub);
        case (c.action)
            ACT_SET:
                if (c.relay < RELAY_COUNT)
                    relay_image[RELAY_POS[c.relay]] = 1'b1;
            ACT_CLEAR:
                if (c.relay < RELAY_COUNT)
                    relay_image[RELAY_POS[c.relay]] = 1'b0;
            ACT_STEP:
            begin
                if (!c.vsel)
                    relay_image = (relay_image & ~VALVE_A_FIELD) | VALVE_A_STEPS[valve_phase[0]];
                else
                    sub_image = (sub_image & ~VALVE_B_FIELD) | VALVE_B_STEPS[valve_phase[1]];
                if (c.back)
                    valve_phase[c.vsel] = valve_phase[c.vsel] - 3'd1;
                else
                    valve_phase[c.vsel] = valve_phase[c.vsel] + 3'd1;
            end
            default: ;
        endcase
        changed = (relay_image != sent_image);
        img = relay_image;
        sub = sub_image[15:12];
        if (changed)
            sent_image = relay_image;
    endfunction

    // Queue the 16 bit requests of one burst, MSB first
    function automatic void queue_burst(input logic [15:0] img, input logic [3:0] sub);
        shift_bit_t b;
        for (int i = 0; i < 16; i++)
        begin
            b.sbit = img[15-i];
            b.strobe = (i == 15);
            b.sub = sub;
            expected_bits.push_back(b);
        end
    endfunction

    // Drive one command request after a random gap, wait for its acceptance
    task automatic send_command(input cmd_row_t c);
        int gap;
        logic changed;
        logic [15:0] img;
        logic [3:0] sub;
        if (send_left == 0)
        begin
            send_free = ($urandom_range(0, 3) == 0);
            send_left = $urandom_range(10, 40);
        end
        send_left--;
        gap = send_free ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.action = c.action;
        cmd_ch.relay_number = c.relay;
        cmd_ch.valve_select = c.vsel;
        cmd_ch.step_back = c.back;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        update_image(c, changed, img, sub);
        if (c.kind == ROW_BURST)
            queue_burst(c.image, c.sub);
        else if (c.kind == ROW_PREDICT && changed)
            queue_burst(img, sub);
        @(negedge clk);
    endtask

    // Compare one accepted bit request with the oldest expectation
    task automatic check_bit();
        shift_bit_t exp_b;
        if (expected_bits.size() == 0)
        begin
            error_count++;
            $display("%0t unexpected bit request: serial_bit=%b latch_strobe=%b sub_valve_bits=%h",
                     $time, bit_ch.serial_bit, bit_ch.latch_strobe, bit_ch.sub_valve_bits);
        end
        else
        begin
            exp_b = expected_bits.pop_front();
            if (bit_ch.serial_bit !== exp_b.sbit)
            begin
                error_count++;
                $display("%0t serial_bit mismatch: expected %b actual %b",
                         $time, exp_b.sbit, bit_ch.serial_bit);
            end
            if (bit_ch.latch_strobe !== exp_b.strobe)
            begin
                error_count++;
                $display("%0t latch_strobe mismatch: expected %b actual %b",
                         $time, exp_b.strobe, bit_ch.latch_strobe);
            end
            if (bit_ch.sub_valve_bits !== exp_b.sub)
            begin
                error_count++;
                $display("%0t sub_valve_bits mismatch: expected %h actual %h",
                         $time, exp_b.sub, bit_ch.sub_valve_bits);
            end
        end
    endtask

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Accept bit requests with random stalls and check each one
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (recv_left == 0)
            begin
                recv_free = ($urandom_range(0, 3) == 0);
                recv_left = $urandom_range(16, 80);
            end
            recv_left--;
            stall = recv_free ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                bit_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            bit_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!bit_ch.valid);
            check_bit();
            @(negedge clk);
        end
    end

    // Reset, directed table, random commands, drain and verdict
    initial
    begin
        cmd_row_t row;
        int pick;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.action = ACT_SET;
        cmd_ch.relay_number = 4'd0;
        cmd_ch.valve_select = 1'b0;
        cmd_ch.step_back = 1'b0;
        bit_ch.ready = 1'b0;
        relay_image = '0;
        sent_image = '0;
        sub_image = '0;
        valve_phase[0] = '0;
        valve_phase[1] = '0;
        error_count = 0;
        cycle_count = 0;
        send_free = 1'b0;
        send_left = 0;
        recv_free = 1'b0;
        recv_left = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_command(directed_rows[i]);

        // Mostly in-range relays and valve steps, some ignored commands
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 6)
                row.action = ACT_SET;
            else if (pick < 11)
                row.action = ACT_CLEAR;
            else if (pick < 15)
                row.action = ACT_STEP;
            else
                row.action = ACT_NONE;
            if ($urandom_range(0, 4) == 0)
                row.relay = 4'($urandom_range(0, 15));
            else
                row.relay = 4'($urandom_range(0, RELAY_COUNT - 1));
            row.vsel = 1'($urandom_range(0, 1));
            row.back = 1'($urandom_range(0, 1));
            row.kind = ROW_PREDICT;
            row.image = '0;
            row.sub = '0;
            send_command(row);
        end
        cmd_ch.valid = 1'b0;

        while (expected_bits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
